/* hdl/rqcs_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rqcs_pkg
// Shared types and constants for the ring queue consumer slot block.
// ---------------------------------------------------------------------------
package rqcs_pkg;

  localparam int RING_SLOTS    = 16;
  localparam int ELEMENT_BYTES = 8;
  localparam int DATA_W        = 64;
  localparam int IDX_W         = $clog2(RING_SLOTS);
  localparam int LEN_W         = $clog2(RING_SLOTS + 1);
  localparam int CNT_W         = 4;   // queued_count / peak_usage
  localparam int CFG_W         = 4;
  localparam int CFG_ADDR_W    = 2;
  localparam int IN_TDATA_W    = 72;  // 69 bits of fields, padded to bytes
  localparam int OUT_TDATA_W   = 80;  // 74 bits of fields, padded to bytes

  localparam logic [CFG_W-1:0] QUEUE_LENGTH_RST = 4'd15;
  localparam logic [CFG_W-1:0] MAX_BYTES_RST    = 4'd8;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_QUEUE_LENGTH = 2'd0,
    CFG_MAX_BYTES    = 2'd1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_TOO_LARGE = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic {
    MODE_WRITE = 1'b0,
    MODE_READ  = 1'b1
  } mode_t;

  // controller -> datapath
  typedef struct packed {
    logic    exec;    // transaction taken this cycle
    logic    wr;      // store payload and advance tail
    logic    rd;      // advance read index and fetch slot
    status_t status;  // result code to report
  } rqcs_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic too_large;
    logic full;
    logic empty;
  } rqcs_stat_t;

endpackage

/* hdl/rqcs_ctrl.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rqcs_ctrl
// Handshake sequencer: takes one transaction, classifies it, holds the result.
// ---------------------------------------------------------------------------
module rqcs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic               in_mode,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  rqcs_pkg::rqcs_stat_t stat,
  output rqcs_pkg::rqcs_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RESP = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   take;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_RESP);
  assign take       = in_tvalid && in_tready;

  always_comb begin
    cmd        = '0;
    cmd.exec   = take;
    cmd.status = rqcs_pkg::ST_OK;
    if (rqcs_pkg::mode_t'(in_mode) == rqcs_pkg::MODE_WRITE) begin
      // size check comes before the full check
      if (stat.too_large) begin
        cmd.status = rqcs_pkg::ST_TOO_LARGE;
      end else if (stat.full) begin
        cmd.status = rqcs_pkg::ST_FULL;
      end else begin
        cmd.wr = take;
      end
    end else begin
      if (stat.empty) begin
        cmd.status = rqcs_pkg::ST_EMPTY;
      end else begin
        cmd.rd = take;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (take) state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hdl/rqcs_dp.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rqcs_dp
// Ring indices, high-water mark, config registers and the slot memory.
// ---------------------------------------------------------------------------
module rqcs_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [rqcs_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [rqcs_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic [rqcs_pkg::DATA_W-1:0]         in_payload,
  input  logic [3:0]                          in_byte_count,
  input  rqcs_pkg::rqcs_cmd_t                 cmd,
  output rqcs_pkg::rqcs_stat_t                stat,
  output logic [1:0]                          res_status,
  output logic [rqcs_pkg::DATA_W-1:0]         res_read_data,
  output logic [rqcs_pkg::CNT_W-1:0]          res_queued_count,
  output logic [rqcs_pkg::CNT_W-1:0]          res_peak_usage
);

  logic [rqcs_pkg::CFG_W-1:0] qlen_r, max_bytes_r;
  logic [rqcs_pkg::IDX_W-1:0] rd_pos_r, tail_pos_r;
  logic [rqcs_pkg::CNT_W-1:0] high_water_r;
  rqcs_pkg::status_t          status_r;
  logic                       rd_ok_r;
  logic [rqcs_pkg::DATA_W-1:0] slot_mem [rqcs_pkg::RING_SLOTS];
  logic [rqcs_pkg::DATA_W-1:0] mem_q_r;

  logic [rqcs_pkg::LEN_W-1:0] ring_len, len_raw;
  logic [rqcs_pkg::IDX_W-1:0] tail_next, rd_next;
  logic [rqcs_pkg::CNT_W-1:0] queued_now, queued_after_wr;
  logic [rqcs_pkg::ELEMENT_BYTES-1:0] byte_en;

  function automatic logic [rqcs_pkg::IDX_W-1:0] next_idx(
    input logic [rqcs_pkg::IDX_W-1:0] idx,
    input logic [rqcs_pkg::LEN_W-1:0] len
  );
    logic [rqcs_pkg::LEN_W-1:0] n;
    n = rqcs_pkg::LEN_W'(idx) + rqcs_pkg::LEN_W'(1);
    if (n >= len) n = '0;
    return n[rqcs_pkg::IDX_W-1:0];
  endfunction

  function automatic logic [rqcs_pkg::CNT_W-1:0] fill(
    input logic [rqcs_pkg::IDX_W-1:0] t,
    input logic [rqcs_pkg::IDX_W-1:0] r,
    input logic [rqcs_pkg::LEN_W-1:0] len
  );
    logic [rqcs_pkg::LEN_W-1:0] d;
    if (t >= r) d = rqcs_pkg::LEN_W'(t) - rqcs_pkg::LEN_W'(r);
    else        d = rqcs_pkg::LEN_W'(t) + len - rqcs_pkg::LEN_W'(r);
    return d[rqcs_pkg::CNT_W-1:0];
  endfunction

  // ring length is capacity + 1, clipped to the physical slot count
  assign len_raw  = rqcs_pkg::LEN_W'(qlen_r) + rqcs_pkg::LEN_W'(1);
  assign ring_len = (len_raw > rqcs_pkg::LEN_W'(rqcs_pkg::RING_SLOTS)) ?
                    rqcs_pkg::LEN_W'(rqcs_pkg::RING_SLOTS) : len_raw;

  assign tail_next       = next_idx(tail_pos_r, ring_len);
  assign rd_next         = next_idx(rd_pos_r, ring_len);
  assign queued_now      = fill(tail_pos_r, rd_pos_r, ring_len);
  assign queued_after_wr = fill(tail_next, rd_pos_r, ring_len);

  assign stat.too_large = (in_byte_count > max_bytes_r) ||
                          (in_byte_count > 4'(rqcs_pkg::ELEMENT_BYTES));
  assign stat.full      = (rqcs_pkg::LEN_W'(queued_now) + rqcs_pkg::LEN_W'(1)) >= ring_len;
  assign stat.empty     = (rd_pos_r == tail_pos_r);

  always_comb begin
    for (int b = 0; b < rqcs_pkg::ELEMENT_BYTES; b++) begin
      byte_en[b] = (4'(b) < in_byte_count);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qlen_r       <= rqcs_pkg::QUEUE_LENGTH_RST;
      max_bytes_r  <= rqcs_pkg::MAX_BYTES_RST;
      rd_pos_r     <= '0;
      tail_pos_r   <= '0;
      high_water_r <= '0;
      status_r     <= rqcs_pkg::ST_OK;
      rd_ok_r      <= 1'b0;
    end else begin
      if (cfg_we && rqcs_pkg::cfg_idx_t'(cfg_addr) == rqcs_pkg::CFG_QUEUE_LENGTH) begin
        // new capacity flushes the queue; slot contents stay
        qlen_r       <= cfg_wdata;
        rd_pos_r     <= '0;
        tail_pos_r   <= '0;
        high_water_r <= '0;
      end else if (cfg_we && rqcs_pkg::cfg_idx_t'(cfg_addr) == rqcs_pkg::CFG_MAX_BYTES) begin
        max_bytes_r <= cfg_wdata;
      end
      if (cmd.exec) begin
        status_r <= cmd.status;
        rd_ok_r  <= cmd.rd;
      end
      if (cmd.wr) begin
        tail_pos_r <= tail_next;
        if (queued_after_wr > high_water_r) high_water_r <= queued_after_wr;
      end
      if (cmd.rd) begin
        rd_pos_r <= rd_next;
      end
    end
  end

  // slot memory: byte-enabled write, registered read
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      for (int b = 0; b < rqcs_pkg::ELEMENT_BYTES; b++) begin
        if (byte_en[b]) slot_mem[tail_next][b*8 +: 8] <= in_payload[b*8 +: 8];
      end
    end
    if (cmd.rd) begin
      mem_q_r <= slot_mem[rd_next];
    end
  end

  assign res_status       = status_r;
  assign res_read_data    = rd_ok_r ? mem_q_r : '0;
  assign res_queued_count = queued_now;
  assign res_peak_usage   = high_water_r;

endmodule

/* hdl/ring_queue_consumer_slot.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ring_queue_consumer_slot
// Single-producer single-consumer ring FIFO of 64-bit elements.
// ---------------------------------------------------------------------------
// Usage:
//   in_* carries one operation per transaction: mode 0 writes the low
//   byte_count bytes of payload at the tail, mode 1 reads the next element.
//   out_* returns exactly one result per operation: status, read data
//   (zero unless a read succeeded), queued count and high-water mark.
//   cfg_* writes queue_length (index 0, flushes the queue) or
//   max_element_bytes (index 1) while no operation is outstanding.
// Timing:
//   The result is valid in the cycle after the input transaction. The block
//   works on one operation at a time; the next one is taken in the cycle
//   after the result transaction. The slot memory read and the status are
//   registered.
// Reset:
//   Indices and high-water mark clear, capacity 15, size limit 8 bytes.
//   Slot contents are not cleared.
// Backpressure:
//   While out_tready is low the result holds and in_tready stays low.
// ---------------------------------------------------------------------------
module ring_queue_consumer_slot (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [rqcs_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [rqcs_pkg::CFG_W-1:0]            cfg_wdata,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // mode [0], payload [64:1], byte_count [68:65], zero [71:69]
  input  logic [rqcs_pkg::IN_TDATA_W-1:0]       in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // status [1:0], read_data [65:2], queued_count [69:66],
  // peak_usage [73:70], zero [79:74]
  output logic [rqcs_pkg::OUT_TDATA_W-1:0]      out_tdata
);

  rqcs_pkg::rqcs_cmd_t  cmd;
  rqcs_pkg::rqcs_stat_t stat;
  logic [1:0]                      res_status;
  logic [rqcs_pkg::DATA_W-1:0]     res_read_data;
  logic [rqcs_pkg::CNT_W-1:0]      res_queued_count;
  logic [rqcs_pkg::CNT_W-1:0]      res_peak_usage;

  rqcs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_mode    (in_tdata[0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  rqcs_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .in_payload       (in_tdata[64:1]),
    .in_byte_count    (in_tdata[68:65]),
    .cmd              (cmd),
    .stat             (stat),
    .res_status       (res_status),
    .res_read_data    (res_read_data),
    .res_queued_count (res_queued_count),
    .res_peak_usage   (res_peak_usage)
  );

  assign out_tdata = {6'd0, res_peak_usage, res_queued_count, res_read_data, res_status};

endmodule

/* hdl/rqcs_chk.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rqcs_chk
// Port-level checks for the ring queue consumer slot, bound to the top level.
// ---------------------------------------------------------------------------
module rqcs_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [rqcs_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // every input transaction produces a result in the next cycle
  a_resp: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("no result after input transaction");

  // failed operations return zero data
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != rqcs_pkg::ST_OK |-> out_tdata[65:2] == '0)
    else $error("nonzero read data on failed operation");

  // the queue never holds more than its high-water mark
  a_peak: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[69:66] <= out_tdata[73:70])
    else $error("queued count above peak usage");

  // an empty report means nothing is queued
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == rqcs_pkg::ST_EMPTY |-> out_tdata[69:66] == '0)
    else $error("empty status with elements queued");

endmodule

bind ring_queue_consumer_slot rqcs_chk u_rqcs_chk (.*);

/* tb/rqcs_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rqcs_checker
// Watches the operation, result and register ports of the ring queue block,
// keeps a shadow of the ring (slots, indices, high-water mark, settings),
// predicts each result and compares it field by field in arrival order.
// ---------------------------------------------------------------------------
module rqcs_checker
  import rqcs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_W-1:0]       cfg_wdata,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  // mode [0], payload [64:1], byte_count [68:65], zero [71:69]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  // status [1:0], read_data [65:2], queued_count [69:66],
  // peak_usage [73:70], zero [79:74]
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  output int                     mismatches,
  output int                     outstanding
);

  typedef struct packed {
    status_t           status;
    logic [DATA_W-1:0] data;
    logic [CNT_W-1:0]  level;
    logic [CNT_W-1:0]  peak;
  } fifo_result_t;

  logic [DATA_W-1:0] slots [RING_SLOTS];
  logic [IDX_W-1:0]  rd_ptr;
  logic [IDX_W-1:0]  wr_ptr;
  logic [CNT_W-1:0]  peak_level;
  logic [CFG_W-1:0]  cap_cfg;
  logic [CFG_W-1:0]  size_limit;

  fifo_result_t pending_results [$];
  fifo_result_t want_result;
  fifo_result_t got_result;

  function automatic int unsigned ring_span();
    int unsigned n;
    n = int'(cap_cfg) + 1;
    return (n > RING_SLOTS) ? RING_SLOTS : n;
  endfunction

  function automatic logic [IDX_W-1:0] step_idx(input logic [IDX_W-1:0] idx);
    int unsigned n;
    n = int'(idx) + 1;
    return (n >= ring_span()) ? '0 : IDX_W'(n);
  endfunction

  function automatic int unsigned fill_level();
    int unsigned w;
    int unsigned r;
    w = wr_ptr;
    r = rd_ptr;
    if (w >= r) return w - r;
    return w + ring_span() - r;
  endfunction

  function automatic fifo_result_t predict_fifo_op(input mode_t op,
                                                   input logic [DATA_W-1:0] data,
                                                   input logic [3:0] nbytes);
    fifo_result_t r;
    logic [DATA_W-1:0] keep;
    logic [IDX_W-1:0] nxt;
    r.status = ST_OK;
    r.data   = '0;
    if (op == MODE_WRITE) begin
      // size is checked ahead of occupancy
      if (nbytes > size_limit || nbytes > ELEMENT_BYTES) begin
        r.status = ST_TOO_LARGE;
      end else if (fill_level() >= ring_span() - 1) begin
        r.status = ST_FULL;
      end else begin
        nxt  = step_idx(wr_ptr);
        keep = (nbytes >= ELEMENT_BYTES) ? '1 : ((64'd1 << (nbytes * 8)) - 64'd1);
        slots[nxt] = (slots[nxt] & ~keep) | (data & keep);
        wr_ptr = nxt;
        if (fill_level() > peak_level) peak_level = CNT_W'(fill_level());
      end
    end else if (rd_ptr == wr_ptr) begin
      r.status = ST_EMPTY;
    end else begin
      rd_ptr = step_idx(rd_ptr);
      r.data = slots[rd_ptr];
    end
    r.level = CNT_W'(fill_level());
    r.peak  = peak_level;
    return r;
  endfunction

  task automatic check_field(input string what, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (want !== got) begin
      if (mismatches < 10)
        $display("rqcs_checker: %s mismatch, expected %0h, got %0h", what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr     = '0;
      wr_ptr     = '0;
      peak_level = '0;
      cap_cfg    = QUEUE_LENGTH_RST;
      size_limit = MAX_BYTES_RST;
      pending_results.delete();
    end else begin
      // a result leaving now belongs to an earlier operation
      if (out_tvalid && out_tready) begin
        got_result.status = status_t'(out_tdata[1:0]);
        got_result.data   = out_tdata[65:2];
        got_result.level  = out_tdata[69:66];
        got_result.peak   = out_tdata[73:70];
        if (pending_results.size() == 0) begin
          if (mismatches < 10)
            $display("rqcs_checker: result with none expected, tdata %0h", out_tdata);
          mismatches++;
        end else begin
          want_result = pending_results.pop_front();
          check_field("status", 64'(want_result.status), 64'(got_result.status));
          check_field("read_data", want_result.data, got_result.data);
          check_field("queued_count", 64'(want_result.level), 64'(got_result.level));
          check_field("peak_usage", 64'(want_result.peak), 64'(got_result.peak));
        end
      end
      if (in_tvalid && in_tready)
        pending_results.push_back(predict_fifo_op(mode_t'(in_tdata[0]), in_tdata[64:1],
                                                  in_tdata[68:65]));
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_addr))
          CFG_QUEUE_LENGTH: begin
            // new capacity flushes the queue, slots keep their data
            cap_cfg    = cfg_wdata;
            rd_ptr     = '0;
            wr_ptr     = '0;
            peak_level = '0;
          end
          CFG_MAX_BYTES: begin
            size_limit = cfg_wdata;
          end
          default: begin
          end
        endcase
      end
    end
    outstanding = pending_results.size();
  end

endmodule

/* tb/tb_ring_queue_consumer_slot.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_ring_queue_consumer_slot
// Drives write and read operations into the ring queue under changing
// capacity and size limits and random idle/stall patterns; the checker
// instance predicts and compares every result.
// ---------------------------------------------------------------------------
module tb_ring_queue_consumer_slot;
  import rqcs_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 4000;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 96;
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_3 = 2'd3;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_ADDR_W-1:0]  cfg_addr;
  logic [CFG_W-1:0]       cfg_wdata;
  logic                   in_tvalid;
  logic                   in_tready;
  // mode [0], payload [64:1], byte_count [68:65], zero [71:69]
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  // status [1:0], read_data [65:2], queued_count [69:66],
  // peak_usage [73:70], zero [79:74]
  logic [OUT_TDATA_W-1:0] out_tdata;

  int mismatches;
  int outstanding;
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int quiet_cycles   = 0;
  logic hold_active;
  logic [CFG_W-1:0] size_limit_now;
  event long_hold;

  int qlen_plan [PHASES] = '{15, 1, 4, 0, 15, 7, 2, 15, 10, 3, 15, 5};
  int maxb_plan [PHASES] = '{8, 1, 15, 8, 8, 0, 8, 5, 2, 8, 7, 4};

  ring_queue_consumer_slot i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  rqcs_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result side: random stalls, overridden by the long hold-off
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      out_tready <= !hold_active && ($urandom_range(99) >= sink_stall_pct);
    end
  end

  initial begin
    hold_active <= 1'b0;
    forever begin
      @(long_hold);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_active <= 1'b0;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  function automatic logic [DATA_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  task automatic push_op(input mode_t op, input logic [DATA_W-1:0] data,
                         input logic [3:0] nbytes);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, nbytes, data, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_W-1:0] val);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    if (idx == CFG_MAX_BYTES) size_limit_now = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    mode_t op;
    logic [3:0] nbytes;
    logic [DATA_W-1:0] data;
    int wr_pct;
    int sel;

    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_addr  <= '0;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    size_limit_now = MAX_BYTES_RST;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill slots 1..15 with whole elements, then wrap into slot 0 so no
    // slot byte is ever read before it was written
    for (int i = 0; i < 15; i++)
      push_op(MODE_WRITE, (i == 0) ? '1 : (i == 1) ? '0 : rand_word(), 4'd8);
    push_op(MODE_READ, rand_word(), 4'd0);
    push_op(MODE_WRITE, rand_word(), 4'd8);
    push_op(MODE_WRITE, rand_word(), 4'd8);    // full
    push_op(MODE_WRITE, rand_word(), 4'd9);    // too large wins over full
    push_op(MODE_WRITE, '1, 4'd15);
    push_op(MODE_READ, '1, 4'd15);
    push_op(MODE_WRITE, rand_word(), 4'd0);    // queues an element, stores nothing
    push_op(MODE_READ, rand_word(), 4'd3);
    push_op(MODE_WRITE, rand_word(), 4'd3);    // partial element

    // capacity zero, size limit zero, writes to unused register indexes
    write_reg(CFG_QUEUE_LENGTH, 4'd0);
    write_reg(CFG_MAX_BYTES, 4'd0);
    write_reg(CFG_SPARE_2, 4'hF);
    write_reg(CFG_SPARE_3, 4'h5);
    push_op(MODE_READ, rand_word(), 4'd0);
    push_op(MODE_WRITE, rand_word(), 4'd0);
    push_op(MODE_WRITE, rand_word(), 4'd1);

    for (int p = 0; p < PHASES; p++) begin
      write_reg(CFG_QUEUE_LENGTH, CFG_W'(qlen_plan[p]));
      write_reg(CFG_MAX_BYTES, CFG_W'(maxb_plan[p]));
      if (p % 5 == 0) write_reg((p == 5) ? CFG_SPARE_3 : CFG_SPARE_2, CFG_W'($urandom));
      case (p % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 58; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 58; end
        default: begin src_idle_pct = 9; sink_stall_pct = 9; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // long receiver hold-off while the sender keeps offering
        if (p == 4 && n == 30) -> long_hold;
        if (p == 6 && n == 48) wait_drained();
        // fill first, then drain, so full and empty both come up
        wr_pct = (n < PHASE_ITEMS / 2) ? 70 : 35;
        if ($urandom_range(99) < wr_pct) op = MODE_WRITE;
        else op = MODE_READ;
        sel = $urandom_range(9);
        if (sel == 0) nbytes = 4'($urandom_range(15));
        else if (sel == 1) nbytes = 4'(ELEMENT_BYTES);
        else nbytes = 4'($urandom_range((size_limit_now > ELEMENT_BYTES) ?
                                        ELEMENT_BYTES : size_limit_now));
        sel = $urandom_range(7);
        if (sel == 0) data = '1;
        else if (sel == 1) data = '0;
        else data = rand_word();
        push_op(op, data, nbytes);
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
